FILE: rtl/text_console_writer_assert.svh
// ============================================================================
// text console writer assertion macros
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined
// ============================================================================
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer assertion failed");

// next-cycle implication
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer assertion failed");

`else

`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TCW_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/tcw_pkg.sv
// ============================================================================
// text console writer package
// cell type and character codes of the text console
// ============================================================================
package tcw_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] attr;
    } cell_t;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] BLANK_ATTR   = 8'h0F;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam cell_t BLANK_CELL = '{ch: BLANK_CHAR, attr: BLANK_ATTR};

endpackage

FILE: rtl/text_console_writer.sv
// ============================================================================
// text console writer
// text-mode console engine: screen store of character and attribute cells,
// a cursor, put and read items, scroll by one row
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    func, character, cell_index
//   out      output     out_valid / out_stall  cursor_column, cursor_row,
//                                              cell_character, cell_attribute,
//                                              scrolled
//   cfg      input      cfg_write              cfg_data (text attribute)
//
// a put item goes straight to the done state, a read item through the read state
// (one registered memory read), straight too when the index is past the last cell
// a put that scrolls moves every row but the top one up a row, one cell copied per cycle
// through the one-read, one-write screen memory, then the bottom row filled
// after reset a clearing pass writes blanks over all COLUMNS*ROWS cells, one
// per cycle, with in_stall high
// a finished result waits in the output register while out_stall is high; the
// next item is taken meanwhile and held in its last state until the slot frees
// ============================================================================
`include "text_console_writer_assert.svh"

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int ROW_W  = $clog2(ROWS),
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_write,
    input  logic [7:0]        cfg_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [7:0]        character,
    input  logic [ADDR_W-1:0] cell_index,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [COL_W-1:0]  cursor_column,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [7:0]        cell_character,
    output logic [7:0]        cell_attribute,
    output logic              scrolled
);

    import tcw_pkg::*;

    localparam int CNT_W = $clog2(CELLS + 1);

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM    = ADDR_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0]  COPY_END  = CNT_W'(CELLS - COLUMNS);
    localparam logic [CNT_W-1:0]  LAST_CELL = CNT_W'(CELLS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   sweep_reg, sweep_next;
    logic [7:0]         attr_reg, attr_next;
    logic [7:0]         res_char_reg, res_char_next;
    logic [7:0]         res_attr_reg, res_attr_next;
    logic               res_scr_reg, res_scr_next;
    logic               out_valid_reg, out_valid_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic [7:0]         out_attr_reg, out_attr_next;
    logic               out_scr_reg, out_scr_next;

    cell_t              screen_mem [CELLS];
    cell_t              rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    cell_t              mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    // screen memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        logic do_scroll;

        do_scroll      = 1'b0;
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        addr_next      = addr_reg;
        sweep_next     = sweep_reg;
        attr_next      = cfg_write ? cfg_data : attr_reg;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;
        res_scr_next   = res_scr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_scr_next   = out_scr_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = BLANK_CELL;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg[ADDR_W-1:0];
                sweep_next = sweep_reg + CNT_W'(1);
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_char_next = '0;
                    res_attr_next = '0;
                    res_scr_next  = 1'b0;
                    state_next    = ST_DONE;
                    if (func == FUNC_READ)
                    begin
                        if (CNT_W'(cell_index) < CNT_W'(CELLS))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cell_index;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        priority if (character == CH_NEWLINE)
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                do_scroll = 1'b1;
                            end
                            else
                            begin
                                row_next  = row_reg + ROW_W'(1);
                                addr_next = addr_reg + ADDR_W'(COLUMNS) - ADDR_W'(col_reg);
                            end
                        end
                        else if (character == CH_BACKSPACE)
                        begin
                            if (col_reg != '0 || row_reg != '0)
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - COL_W'(1);
                                end
                                else
                                begin
                                    col_next = LAST_COL;
                                    row_next = row_reg - ROW_W'(1);
                                end
                                addr_next      = addr_reg - ADDR_W'(1);
                                mem_we         = 1'b1;
                                mem_waddr      = addr_reg - ADDR_W'(1);
                                mem_wdata.ch   = '0;
                                mem_wdata.attr = attr_reg;
                            end
                        end
                        else
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = addr_reg;
                            mem_wdata.ch   = character;
                            mem_wdata.attr = attr_reg;
                            addr_next      = addr_reg + ADDR_W'(1);
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    do_scroll = 1'b1;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                            end
                        end
                        if (do_scroll)
                        begin
                            col_next     = '0;
                            row_next     = LAST_ROW;
                            addr_next    = BOTTOM;
                            sweep_next   = '0;
                            res_scr_next = 1'b1;
                            state_next   = ST_COPY;
                        end
                    end
                end
            end

            ST_READ:
            begin
                res_char_next = rd_data_reg.ch;
                res_attr_next = rd_data_reg.attr;
                state_next    = ST_DONE;
            end

            // read cell k+COLUMNS while writing cell k-1 from the previous read
            ST_COPY:
            begin
                if (sweep_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(sweep_reg - CNT_W'(1));
                    mem_wdata = rd_data_reg;
                end
                if (sweep_reg == COPY_END)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(sweep_reg + CNT_W'(COLUMNS));
                    sweep_next = sweep_reg + CNT_W'(1);
                end
            end

            ST_FILL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg[ADDR_W-1:0];
                sweep_next = sweep_reg + CNT_W'(1);
                if (sweep_reg == LAST_CELL)
                begin
                    sweep_next = '0;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = col_reg;
                    out_row_next   = row_reg;
                    out_char_next  = res_char_reg;
                    out_attr_next  = res_attr_reg;
                    out_scr_next   = res_scr_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            col_reg       <= '0;
            row_reg       <= '0;
            addr_reg      <= '0;
            sweep_reg     <= '0;
            attr_reg      <= BLANK_ATTR;
            res_char_reg  <= '0;
            res_attr_reg  <= '0;
            res_scr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_char_reg  <= '0;
            out_attr_reg  <= '0;
            out_scr_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            addr_reg      <= addr_next;
            sweep_reg     <= sweep_next;
            attr_reg      <= attr_next;
            res_char_reg  <= res_char_next;
            res_attr_reg  <= res_attr_next;
            res_scr_reg   <= res_scr_next;
            out_valid_reg <= out_valid_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_char_reg  <= out_char_next;
            out_attr_reg  <= out_attr_next;
            out_scr_reg   <= out_scr_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_column  = out_col_reg;
    assign cursor_row     = out_row_reg;
    assign cell_character = out_char_reg;
    assign cell_attribute = out_attr_reg;
    assign scrolled       = out_scr_reg;

    // cursor address tracks row and column
    `TCW_ASSERT_IMP(a_addr_track, clk, rst_n, state_reg == ST_IDLE,
        addr_reg == ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg)))
    // a scroll leaves the cursor at the start of the last row
    `TCW_ASSERT_IMP(a_scroll_home, clk, rst_n, state_reg == ST_DONE && res_scr_reg,
        row_reg == LAST_ROW && col_reg == '0)
    // a cell read never reports a scroll
    `TCW_ASSERT_IMP(a_read_no_scroll, clk, rst_n, state_reg == ST_READ,
        !res_scr_reg)
    // the copy sweep hands over to the fill at the bottom row
    `TCW_ASSERT_NXT(a_copy_to_fill, clk, rst_n,
        state_reg == ST_COPY && sweep_reg == COPY_END,
        state_reg == ST_FILL && sweep_reg == COPY_END)

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// text console writer testbench
// drives put and read items through the valid/stall input channel while a
// scoreboard mirrors the screen store, cursor and text attribute; every result
// is checked field by field against the mirrored state, across phases with
// different idle and stall rates and text attribute settings
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic [7:0] cell_character;
        logic [7:0] cell_attribute;
        logic       scrolled;
    } console_report_t;

    class console_scoreboard;
        cell_t screen [CELLS];
        int unsigned cursor;
        logic [7:0] attribute;
        console_report_t reports_due [$];
        int unsigned mismatches;

        function new();
            foreach (screen[k])
                screen[k] = BLANK_CELL;
            cursor = 0;
            attribute = BLANK_ATTR;
            mismatches = 0;
        endfunction

        function void line_feed(inout int row, inout logic did_scroll);
            if (row == ROWS - 1)
            begin
                for (int k = 0; k < CELLS - COLUMNS; k++)
                    screen[k] = screen[k + COLUMNS];
                for (int k = CELLS - COLUMNS; k < CELLS; k++)
                    screen[k] = BLANK_CELL;
                did_scroll = 1'b1;
            end
            else
                row++;
        endfunction

        function void note_item(logic f, logic [7:0] c, logic [10:0] idx);
            console_report_t report;
            int col;
            int row;
            logic did_scroll;
            report = '0;
            did_scroll = 1'b0;
            col = cursor % COLUMNS;
            row = cursor / COLUMNS;
            if (f == FUNC_READ)
            begin
                if (idx < CELLS)
                begin
                    report.cell_character = screen[idx].ch;
                    report.cell_attribute = screen[idx].attr;
                end
            end
            else if (c == CH_NEWLINE)
            begin
                col = 0;
                line_feed(row, did_scroll);
                cursor = row * COLUMNS + col;
            end
            else if (c == CH_BACKSPACE)
            begin
                if (col != 0 || row != 0)
                begin
                    if (col != 0)
                        col--;
                    else
                    begin
                        row--;
                        col = COLUMNS - 1;
                    end
                    screen[row * COLUMNS + col] = '{ch: 8'h00, attr: attribute};
                    cursor = row * COLUMNS + col;
                end
            end
            else
            begin
                screen[row * COLUMNS + col] = '{ch: c, attr: attribute};
                col++;
                if (col == COLUMNS)
                begin
                    col = 0;
                    line_feed(row, did_scroll);
                end
                cursor = row * COLUMNS + col;
            end
            report.cursor_column = 7'(col);
            report.cursor_row = 5'(row);
            report.scrolled = did_scroll;
            reports_due.push_back(report);
        endfunction

        function void check_result(console_report_t got);
            console_report_t want;
            if (reports_due.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            if (got.cursor_column !== want.cursor_column)
            begin
                $error("cursor_column: expected %0d, got %0d",
                       want.cursor_column, got.cursor_column);
                mismatches++;
            end
            if (got.cursor_row !== want.cursor_row)
            begin
                $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
                mismatches++;
            end
            if (got.cell_character !== want.cell_character)
            begin
                $error("cell_character: expected 0x%02h, got 0x%02h",
                       want.cell_character, got.cell_character);
                mismatches++;
            end
            if (got.cell_attribute !== want.cell_attribute)
            begin
                $error("cell_attribute: expected 0x%02h, got 0x%02h",
                       want.cell_attribute, got.cell_attribute);
                mismatches++;
            end
            if (got.scrolled !== want.scrolled)
            begin
                $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [7:0]  character;
    logic [10:0] cell_index;
    logic        out_valid;
    logic        out_stall;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [7:0]  cell_character;
    logic [7:0]  cell_attribute;
    logic        scrolled;

    console_scoreboard sb;
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_cycles = 0;
    int unsigned cycle_count = 0;

    text_console_writer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .character      (character),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .cell_character (cell_character),
        .cell_attribute (cell_attribute),
        .scrolled       (scrolled)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_item(func, character, cell_index);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(console_report_t'{cursor_column, cursor_row, cell_character,
                                              cell_attribute, scrolled});
    end

    // receiver side: random stalls, or a long hold-off when requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input logic f, input logic [7:0] c, input logic [10:0] idx);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        character <= c;
        cell_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        cfg_data <= value;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.attribute = value;
    endtask

    function automatic logic [10:0] pick_read_index();
        int near;
        near = 0;
        case ($urandom_range(3))
            0, 1:
            begin
                near = int'(sb.cursor) - int'($urandom_range(90));
                if (near < 0)
                    near = 0;
                return near[10:0];
            end
            2: return 11'($urandom_range(2047));
            default: return 11'($urandom_range(CELLS - 1));
        endcase
    endfunction

    // lines of text with reads and backspaces mixed in, ended by newline, at times followed by backspaces
    task automatic type_lines(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned roll;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(19) == 0) ? $urandom_range(95, 75) : $urandom_range(8);
            for (int unsigned k = 0; k < len; k++)
            begin
                roll = $urandom_range(99);
                if (roll < 15)
                    send_item(FUNC_READ, 8'($urandom), pick_read_index());
                else if (roll < 21)
                    send_item(FUNC_PUT, CH_BACKSPACE, 11'($urandom));
                else if (roll < 25)
                    send_item(FUNC_PUT, 8'($urandom), 11'($urandom));
                else
                    send_item(FUNC_PUT, 8'($urandom_range(8'h7E, 8'h21)), 11'($urandom));
                sent++;
            end
            send_item(FUNC_PUT, CH_NEWLINE, 11'($urandom));
            sent++;
            if ($urandom_range(9) == 0)
            begin
                len = $urandom_range(3, 1);
                for (int unsigned k = 0; k < len; k++)
                    send_item(FUNC_PUT, CH_BACKSPACE, 11'($urandom));
                sent += len;
            end
        end
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall,
                             input logic [7:0] attr, input int unsigned hold,
                             input int unsigned n_items);
        write_attribute(attr);
        send_gap_pct = gap;
        stall_pct = stall;
        hold_cycles = hold;
        type_lines(n_items);
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = 8'h00;
        in_valid = 1'b0;
        func = FUNC_PUT;
        character = 8'h00;
        cell_index = 11'd0;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents, out of range reads, home backspace, wraps
        send_item(FUNC_READ, 8'h00, 11'd0);
        send_item(FUNC_READ, 8'hFF, 11'd1999);
        send_item(FUNC_READ, 8'h00, 11'd2000);
        send_item(FUNC_READ, 8'hFF, 11'd2047);
        send_item(FUNC_PUT, CH_BACKSPACE, 11'd0);
        send_item(FUNC_PUT, 8'hFF, 11'd2047);
        send_item(FUNC_PUT, 8'h00, 11'd0);
        send_item(FUNC_PUT, 8'h41, 11'd5);
        send_item(FUNC_PUT, CH_BACKSPACE, 11'd0);
        send_item(FUNC_READ, 8'h00, 11'd2);
        send_item(FUNC_PUT, CH_NEWLINE, 11'd0);
        send_item(FUNC_PUT, CH_BACKSPACE, 11'd0);
        send_item(FUNC_READ, 8'h00, 11'd79);
        send_item(FUNC_PUT, 8'h7E, 11'd0);
        send_item(FUNC_READ, 8'h00, 11'd0);
        send_item(FUNC_READ, 8'h00, 11'd1);
        send_item(FUNC_PUT, CH_NEWLINE, 11'd0);
        settle();

        run_phase(0, 0, 8'h00, 0, 110);
        run_phase(48, 0, 8'hFF, 0, 110);
        run_phase(0, 48, 8'($urandom), 400, 110);
        run_phase(30, 30, 8'($urandom), 0, 110);
        run_phase(0, 0, BLANK_ATTR, 0, 90);

        if (sb.mismatches == 0 && sb.reports_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
